// ===== hw/rtl/sine_tone_with_gain_ramp_assert.svh =====
// Assertion macros for the checker of this block.
// Each macro expects clock and reset to be visible where it is used.
`ifndef SINE_TONE_WITH_GAIN_RAMP_ASSERT_SVH
`define SINE_TONE_WITH_GAIN_RAMP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define STGR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stgr check failed");

// Consequent holds in the cycle after the antecedent.
`define STGR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stgr check failed");

`endif

// ===== hw/rtl/stgr_pkg.sv =====
package stgr_pkg;

   // Default sizes
   localparam int DEF_SINE_TABLE_DEPTH = 1024;
   localparam int DEF_SAMPLE_WIDTH     = 16;
   localparam int DEF_GAIN_TABLE_DEPTH = 256;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_GAIN_DB = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SAMPLES   = 2'd2;

   // Field widths
   localparam int PHASE_W = 32;
   localparam int DB_W    = 16;
   localparam int RAMP_W  = 24;
   localparam int GAIN_W  = 32;   // current gain, dB in Q7.24
   localparam int STEP_W  = 31;   // magnitude of the per-sample gain step
   localparam int LIN_W   = 16;   // entry of the dB to linear table

   // Reset values
   localparam logic [PHASE_W-1:0]       PHASE_STEP_RST     = '0;
   localparam logic signed [DB_W-1:0]   TARGET_GAIN_DB_RST = -16'sd30720;
   localparam logic [RAMP_W-1:0]        RAMP_SAMPLES_RST   = 24'd4800;
   localparam logic signed [GAIN_W-1:0] CURRENT_GAIN_RST   = 32'sh8800_0000;

   // log2(10)/20 in Q32
   localparam logic [29:0] DB_TO_LOG2_Q32 = 30'd713378626;
   localparam logic [STEP_W:0] STEP_MAX   = 32'h7FFF_FFFF;

   // Serial divider
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = RAMP_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // Table construction constants
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] LN2_Q30     = 64'd744261118;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Sequencer strobes to the datapath
   typedef struct packed {
      logic div_start;
      logic step_load;
      logic advance;
      logic mul_gain;
      logic gain_index;
      logic mul_sample;
      logic emit;
   } ctrl_type;

   // sin of (r / 2^30) quarter turns in Q30, r in [0, 2^30]
   function automatic logic [63:0] quarter_sin(input logic [63:0] r);
      logic [63:0]        x;
      logic [63:0]        t;
      logic signed [63:0] s;
      int                 n;
      x = (r * HALF_PI_Q30) >> 30;
      t = x;
      s = signed'(x);
      for (n = 1; n <= 6; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / 64'((2 * n) * (2 * n + 1));
         if (n[0]) s = s - signed'(t);
         else s = s + signed'(t);
      end
      if (s < 0) s = '0;
      if (s > signed'(ONE_Q30)) s = signed'(ONE_Q30);
      return unsigned'(s);
   endfunction

   // exp series of y (Q30), result Q30
   function automatic logic [63:0] exp_series(input logic [63:0] y);
      logic [63:0] t;
      logic [63:0] s;
      int          n;
      t = ONE_Q30;
      s = ONE_Q30;
      for (n = 1; n <= 12; n++) begin
         t = ((t * y) >> 30) / 64'(n);
         s = s + t;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/stgr_rom.sv =====
module stgr_rom #(
   parameter int SINE_TABLE_DEPTH = stgr_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = stgr_pkg::DEF_SAMPLE_WIDTH,
   parameter int GAIN_TABLE_DEPTH = stgr_pkg::DEF_GAIN_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] sine_addr,
   input  logic [$clog2(GAIN_TABLE_DEPTH)-1:0] gain_addr,
   output logic signed [SAMPLE_WIDTH-1:0]      sine_data,
   output logic [stgr_pkg::LIN_W-1:0]          gain_data
);
   import stgr_pkg::*;

   typedef logic signed [SAMPLE_WIDTH-1:0] sine_table_type [SINE_TABLE_DEPTH];
   typedef logic [LIN_W-1:0] gain_table_type [GAIN_TABLE_DEPTH];

   // round(sin(2 pi k / depth) * peak), quadrant symmetry
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      logic [63:0]    u;
      logic [63:0]    r;
      logic [63:0]    s;
      logic [63:0]    v;
      logic [63:0]    peak;
      logic [1:0]     quad;
      int             k;
      peak = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
      for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
         u    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
         quad = u[31:30];
         r    = {34'd0, u[29:0]};
         if (!quad[0]) s = quarter_sin(r);
         else s = quarter_sin(ONE_Q30 - r);
         v = (s * peak + (64'd1 << 29)) >> 30;
         if (quad[1]) tab[k] = SAMPLE_WIDTH'(64'd0 - v);
         else tab[k] = SAMPLE_WIDTH'(v);
      end
      return tab;
   endfunction

   // round(2^(i / depth) * 2^15)
   function automatic gain_table_type build_gain_table();
      gain_table_type tab;
      logic [63:0]    y;
      logic [63:0]    v;
      int             k;
      for (k = 0; k < GAIN_TABLE_DEPTH; k++) begin
         y = (64'(k) * LN2_Q30) / 64'(GAIN_TABLE_DEPTH);
         v = (exp_series(y) + (64'd1 << 14)) >> 15;
         if (v > 64'd65535) tab[k] = '1;
         else tab[k] = LIN_W'(v);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam gain_table_type GAIN_TABLE = build_gain_table();

   logic signed [SAMPLE_WIDTH-1:0] sine_data_ff;
   logic [LIN_W-1:0]               gain_data_ff;

   always_ff @(posedge clock) begin
      sine_data_ff <= SINE_TABLE[sine_addr];
      gain_data_ff <= GAIN_TABLE[gain_addr];
   end

   assign sine_data = sine_data_ff;
   assign gain_data = gain_data_ff;

endmodule

// ===== hw/rtl/stgr_div.sv =====
module stgr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [stgr_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [stgr_pkg::DIV_DEN_W-1:0] divisor,
   output logic                           busy,
   output logic [stgr_pkg::DIV_NUM_W-1:0] quotient,
   output logic                           rem_nonzero
);
   import stgr_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W+1:0] trial;

   // one quotient bit per cycle, restoring
   assign rem_shift = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         if (!trial[DIV_DEN_W+1]) begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         if (count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy        = busy_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = |rem_ff;

endmodule

// ===== hw/rtl/stgr_seq.sv =====
module stgr_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_restart_ramp,
   input  logic               div_busy,
   input  logic               rsp_free,
   output logic               req_ready,
   output stgr_pkg::ctrl_type ctrl
);
   import stgr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_ADV   = 3'd2;
   localparam logic [2:0] ST_MULG  = 3'd3;
   localparam logic [2:0] ST_GIDX  = 3'd4;
   localparam logic [2:0] ST_GROM  = 3'd5;
   localparam logic [2:0] ST_MULS  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart_ramp) begin
                  ctrl.div_start = 1'b1;
                  state_in       = ST_DIV;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               ctrl.step_load = 1'b1;
               state_in       = ST_ADV;
            end
         end
         ST_ADV: begin
            ctrl.advance = 1'b1;
            state_in     = ST_MULG;
         end
         ST_MULG: begin
            ctrl.mul_gain = 1'b1;
            state_in      = ST_GIDX;
         end
         ST_GIDX: begin
            ctrl.gain_index = 1'b1;
            state_in        = ST_GROM;
         end
         ST_GROM: begin
            state_in = ST_MULS;
         end
         ST_MULS: begin
            ctrl.mul_sample = 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (rsp_free) begin
               ctrl.emit = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/sine_tone_with_gain_ramp.sv =====
// Sine tone generator with a dB gain ramp.
// Request channel (req_): each transfer asks for one sample; req_restart_ramp set
// recomputes the per-sample gain step so that the current gain reaches the target
// within ramp_samples samples (one serial division) before the sample is made.
// Response channel (rsp_): one transfer per request, carrying the scaled sample, the
// current gain in dB (Q7.8) and a flag that the gain sits at the target.
// Configuration channel (csr_): always ready; index 0 phase step, 1 target gain,
// 2 ramp length, 3 ignored. Write only while no request is in progress.
// Steps after a request transfer: advance, gain product, table index, table read,
// sample product, emit; a restart first waits for the bit-serial divider. No new
// request is taken until the emit; the sequencer walks one shared multiplier
// through the gain and sample products, so one sample is in work at a time.
// Reset clears phase, sets the gain to -120 dB with a zero step and loads the
// register defaults; the tables are constant and need no fill.
// When the receiver stalls, the result waits in the output register; one further
// request is taken and worked up to its result, which then holds until room frees.
module sine_tone_with_gain_ramp #(
   parameter int SINE_TABLE_DEPTH = stgr_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = stgr_pkg::DEF_SAMPLE_WIDTH,
   parameter int GAIN_TABLE_DEPTH = stgr_pkg::DEF_GAIN_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_restart_ramp,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   output logic signed [stgr_pkg::DB_W-1:0]   rsp_gain_now_db,
   output logic                               rsp_ramp_done,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stgr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import stgr_pkg::*;

   localparam int SIDX_W    = $clog2(SINE_TABLE_DEPTH);
   localparam int SDEPTH_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int GIDX_W    = $clog2(GAIN_TABLE_DEPTH);
   localparam int GDEPTH_W  = $clog2(GAIN_TABLE_DEPTH + 1);
   localparam int MAG_W     = SAMPLE_WIDTH - 1 + LIN_W;   // |sine| times table entry
   localparam int EXT_W     = MAG_W + 16;                 // room for a left shift of 15
   localparam int FRAC_HI_W = 36;                         // fraction bits used for lookup
   localparam logic [SAMPLE_WIDTH-2:0] PEAK = '1;
   // shift = floor(log2 gain) - 15, with the log offset of 32 folded in
   localparam logic signed [6:0] SHIFT_BIAS = 7'sd47;

   // ---------------------------------------------------------------- registers
   logic [PHASE_W-1:0]        phase_step_ff;
   logic signed [DB_W-1:0]    target_gain_db_ff;
   logic [RAMP_W-1:0]         ramp_samples_ff;
   logic [PHASE_W-1:0]        phase_acc_ff, phase_acc_in;
   logic signed [GAIN_W-1:0]  current_gain_ff, current_gain_in;
   logic [STEP_W-1:0]         step_mag_ff, step_mag_in;
   logic [SIDX_W-1:0]         sidx_ff, sidx_in;
   logic signed [61:0]        mult_ff, mult_in;
   logic [GIDX_W-1:0]         gidx_ff, gidx_in;
   logic signed [6:0]         shift_ff, shift_in;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, sample_in;
   logic signed [DB_W-1:0]    rsp_gain_ff;
   logic                      rsp_done_ff;

   ctrl_type                  ctrl;
   logic                      rsp_free;
   logic                      div_busy;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= PHASE_STEP_RST;
         target_gain_db_ff <= TARGET_GAIN_DB_RST;
         ramp_samples_ff   <= RAMP_SAMPLES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_STEP:     phase_step_ff     <= csr_data[PHASE_W-1:0];
            CSR_TARGET_GAIN_DB: target_gain_db_ff <= csr_data[DB_W-1:0];
            CSR_RAMP_SAMPLES:   ramp_samples_ff   <= csr_data[RAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   stgr_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_restart_ramp (req_restart_ramp),
      .div_busy         (div_busy),
      .rsp_free         (rsp_free),
      .req_ready        (req_ready),
      .ctrl             (ctrl)
   );

   // ---------------------------------------------------------------- ramp step
   // Target in Q7.24 and the distance to it, both with headroom.
   logic signed [GAIN_W-1:0]  target_q24;
   logic signed [GAIN_W+1:0]  cur_ext, tgt_ext, diff_ext, diff_abs;
   logic [DIV_DEN_W-1:0]      div_den;
   logic [DIV_NUM_W-1:0]      div_quo;
   logic                      div_rem_nz;
   logic [DIV_NUM_W:0]        quo_ceil;

   assign target_q24 = {target_gain_db_ff, 16'h0000};
   assign cur_ext    = (GAIN_W + 2)'(current_gain_ff);
   assign tgt_ext    = (GAIN_W + 2)'(target_q24);
   assign diff_ext   = tgt_ext - cur_ext;
   assign diff_abs   = diff_ext[GAIN_W+1] ? -diff_ext : diff_ext;
   // a ramp length of zero counts as one sample
   assign div_den    = (ramp_samples_ff == '0) ? DIV_DEN_W'(1) : ramp_samples_ff;

   stgr_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (ctrl.div_start),
      .dividend    (diff_abs[DIV_NUM_W-1:0]),
      .divisor     (div_den),
      .busy        (div_busy),
      .quotient    (div_quo),
      .rem_nonzero (div_rem_nz)
   );

   // round the quotient up, then saturate to the largest step
   assign quo_ceil    = (DIV_NUM_W + 1)'(div_quo) + (DIV_NUM_W + 1)'(div_rem_nz);
   assign step_mag_in = (quo_ceil > (DIV_NUM_W + 1)'(STEP_MAX)) ? STEP_MAX[STEP_W-1:0]
                                                                : quo_ceil[STEP_W-1:0];

   // ---------------------------------------------------------------- phase and gain
   logic [PHASE_W+SDEPTH_W-1:0] sidx_prod;
   logic signed [GAIN_W+1:0]    step_ext, gain_up, gain_down;

   assign sidx_prod    = (PHASE_W + SDEPTH_W)'(phase_acc_ff)
                       * (PHASE_W + SDEPTH_W)'(SINE_TABLE_DEPTH);
   assign sidx_in      = sidx_prod[PHASE_W +: SIDX_W];
   assign phase_acc_in = phase_acc_ff + phase_step_ff;

   // move one step toward the target and never pass it
   assign step_ext  = signed'((GAIN_W + 2)'(step_mag_ff));
   assign gain_up   = cur_ext + step_ext;
   assign gain_down = cur_ext - step_ext;

   always_comb begin
      current_gain_in = current_gain_ff;
      if (cur_ext < tgt_ext) begin
         current_gain_in = (gain_up > tgt_ext) ? target_q24 : gain_up[GAIN_W-1:0];
      end else if (cur_ext > tgt_ext) begin
         current_gain_in = (gain_down < tgt_ext) ? target_q24 : gain_down[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         current_gain_ff <= CURRENT_GAIN_RST;
         step_mag_ff     <= '0;
      end else begin
         if (ctrl.step_load) step_mag_ff <= step_mag_in;
         if (ctrl.advance) begin
            phase_acc_ff    <= phase_acc_in;
            current_gain_ff <= current_gain_in;
         end
      end
   end

   // ---------------------------------------------------------------- tables
   logic signed [SAMPLE_WIDTH-1:0] sine_rd;
   logic [LIN_W-1:0]               gain_rd;

   stgr_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH)
   ) u_rom (
      .clock     (clock),
      .sine_addr (sidx_ff),
      .gain_addr (gidx_ff),
      .sine_data (sine_rd),
      .gain_data (gain_rd)
   );

   // ---------------------------------------------------------------- shared multiplier
   // First pass: gain in dB times log2(10)/20 gives log2 of the linear gain (Q56).
   // Second pass: |sine| times the 2^fraction table entry.
   logic                           sine_neg;
   logic [SAMPLE_WIDTH-1:0]        sine_abs_full;
   logic [SAMPLE_WIDTH-2:0]        sine_abs;
   logic signed [32:0]             mul_op_a, mul_op_b;
   logic signed [65:0]             mul_prod;

   assign sine_neg      = sine_rd[SAMPLE_WIDTH-1];
   assign sine_abs_full = sine_neg ? -sine_rd : sine_rd;
   assign sine_abs      = sine_abs_full[SAMPLE_WIDTH-2:0];

   assign mul_op_a = ctrl.mul_sample ? signed'(33'(sine_abs)) : 33'(current_gain_ff);
   assign mul_op_b = ctrl.mul_sample ? signed'(33'(gain_rd)) : signed'(33'(DB_TO_LOG2_Q32));
   assign mul_prod = mul_op_a * mul_op_b;
   assign mult_in  = mul_prod[61:0];

   // ---------------------------------------------------------------- table index, shift
   // Offset the log by 2^61 so it is positive: flip its top bit.
   logic [61:0]                    log_off;
   logic [FRAC_HI_W+GDEPTH_W-1:0]  gidx_prod;

   assign log_off   = {~mult_ff[61], mult_ff[60:0]};
   assign gidx_prod = (FRAC_HI_W + GDEPTH_W)'(log_off[55:20])
                    * (FRAC_HI_W + GDEPTH_W)'(GAIN_TABLE_DEPTH);
   assign gidx_in   = gidx_prod[FRAC_HI_W +: GIDX_W];
   assign shift_in  = signed'({1'b0, log_off[61:56]}) - SHIFT_BIAS;

   always_ff @(posedge clock) begin
      if (ctrl.advance) sidx_ff <= sidx_in;
      if (ctrl.mul_gain || ctrl.mul_sample) mult_ff <= mult_in;
      if (ctrl.gain_index) begin
         gidx_ff  <= gidx_in;
         shift_ff <= shift_in;
      end
   end

   // ---------------------------------------------------------------- scale and saturate
   logic [MAG_W-1:0]   mag;
   logic [5:0]         shr_pre;
   logic [MAG_W-1:0]   shr_part;
   logic [MAG_W:0]     shr_round;
   logic [EXT_W-1:0]   mag_shifted;
   logic [SAMPLE_WIDTH-2:0] mag_sat;

   assign mag       = mult_ff[MAG_W-1:0];
   // right shift by d with rounding half up: shift by d-1, add one, drop a bit
   assign shr_pre   = 6'(-shift_ff - 7'sd1);
   assign shr_part  = mag >> shr_pre;
   assign shr_round = (MAG_W + 1)'(shr_part) + (MAG_W + 1)'(1);

   always_comb begin
      if (shift_ff[6]) begin
         mag_shifted = EXT_W'(shr_round[MAG_W:1]);
      end else if (shift_ff >= 7'sd16) begin
         mag_shifted = (mag != '0) ? EXT_W'(PEAK) : '0;
      end else begin
         mag_shifted = EXT_W'(mag) << shift_ff[3:0];
      end
      mag_sat   = (mag_shifted > EXT_W'(PEAK)) ? PEAK : mag_shifted[SAMPLE_WIDTH-2:0];
      sample_in = sine_neg ? -signed'({1'b0, mag_sat}) : signed'({1'b0, mag_sat});
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_sample_ff <= sample_in;
         rsp_gain_ff   <= current_gain_ff[GAIN_W-1 -: DB_W];
         rsp_done_ff   <= (current_gain_ff == target_q24);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_gain_now_db = rsp_gain_ff;
   assign rsp_ramp_done   = rsp_done_ff;

endmodule

// ===== hw/rtl/stgr_checker.sv =====
`include "sine_tone_with_gain_ramp_assert.svh"

module stgr_checker #(
   parameter int SAMPLE_WIDTH = stgr_pkg::DEF_SAMPLE_WIDTH
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0]   rsp_sample_out,
   input logic signed [stgr_pkg::DB_W-1:0] rsp_gain_now_db,
   input logic                             rsp_ramp_done
);
   import stgr_pkg::*;

   // one request in work at a time: busy right after a transfer
   `STGR_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // a result never appears in the cycle after its request
   `STGR_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid))

   // a new result follows a busy cycle of the sequencer
   `STGR_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), !$past(req_ready))

   // a stalled result holds
   `STGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_sample_out) && $stable(rsp_gain_now_db)
      && $stable(rsp_ramp_done))

endmodule

bind sine_tone_with_gain_ramp stgr_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_checker (.*);

// ===== tb/sv/tb_sine_tone_with_gain_ramp.sv =====
`timescale 1ns / 100ps

module tb_sine_tone_with_gain_ramp;
   import stgr_pkg::*;

   typedef longint unsigned u64_type;
   typedef longint          s64_type;

   localparam int      SINE_DEPTH  = DEF_SINE_TABLE_DEPTH;
   localparam int      SAMPLE_W    = DEF_SAMPLE_WIDTH;
   localparam int      LIN_DEPTH   = DEF_GAIN_TABLE_DEPTH;
   localparam u64_type PEAK        = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
   localparam u64_type Q30_ONE     = 64'd1 << 30;
   localparam u64_type QUARTER_RAD = 64'd1686629713;   // pi/2 in Q30
   localparam u64_type LN_TWO      = 64'd744261118;    // ln 2 in Q30
   localparam s64_type DB_LOG2     = 64'sd713378626;   // log2(10)/20 in Q32
   localparam s64_type STEP_LIMIT  = 64'sd2147483647;
   localparam int      CYCLE_LIMIT = 400000;
   localparam int      LONG_HOLD   = 300;
   localparam int      TAIL_CYCLES = 60;
   // Index 3 has no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [DB_W-1:0]     gain_db;
      logic                       done;
   } tone_result_type;

   // DUT connections; every input starts at a known value
   logic                         clock;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic                         req_restart_ramp = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic signed [DB_W-1:0]       rsp_gain_now_db;
   logic                         rsp_ramp_done;
   logic                         csr_valid        = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index        = '0;
   logic [CSR_DATA_W-1:0]        csr_data         = '0;

   // Tone model: tables, settings and running state
   int              sine_tab [SINE_DEPTH];
   logic [15:0]     lin_tab [LIN_DEPTH];
   logic [31:0]     tone_phase_step;
   logic signed [15:0] tone_target;
   logic [23:0]     tone_ramp;
   logic [31:0]     tone_phase;
   int              tone_gain;
   int              tone_step;

   // Stimulus and scoreboard
   logic            tone_pending_q [$];
   tone_result_type tone_expected_q [$];
   int              mismatches   = 0;
   int              sample_count = 0;
   int              cycle_count  = 0;
   bit              req_taken    = 1'b0;
   int              send_gap     = 0;
   int              hold_left    = 0;
   bit              quiet_sender   = 1'b0;
   bit              quiet_receiver = 1'b0;
   bit              long_hold_ask  = 1'b0;

   sine_tone_with_gain_ramp u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart_ramp (req_restart_ramp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_gain_now_db  (rsp_gain_now_db),
      .rsp_ramp_done    (rsp_ramp_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sin of (r / 2^30) quarter turns, Q30 result held within [0, 1]
   function automatic s64_type quarter_wave(input u64_type r);
      u64_type x;
      u64_type t;
      s64_type s;
      x = (r * QUARTER_RAD) >> 30;
      t = x;
      s = s64_type'(x);
      for (int n = 1; n <= 6; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / u64_type'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) s = s - s64_type'(t);
         else s = s + s64_type'(t);
      end
      if (s < 0) s = 0;
      if (s > s64_type'(Q30_ONE)) s = s64_type'(Q30_ONE);
      return s;
   endfunction

   // Fill the sine table (quadrant symmetry) and the 2^(i/depth) fraction table
   function automatic void build_tone_tables();
      u64_type u;
      u64_type quad;
      u64_type r;
      u64_type v;
      u64_type t;
      u64_type acc;
      u64_type y;
      s64_type s;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         u    = (u64_type'(k) << 32) / u64_type'(SINE_DEPTH);
         quad = (u >> 30) & 64'd3;
         r    = u & (Q30_ONE - 64'd1);
         if (quad == 0 || quad == 2) s = quarter_wave(r);
         else s = quarter_wave(Q30_ONE - r);
         v = (u64_type'(s) * PEAK + (64'd1 << 29)) >> 30;
         sine_tab[k] = (quad >= 2) ? -int'(v) : int'(v);
      end
      for (int k = 0; k < LIN_DEPTH; k++) begin
         y   = (u64_type'(k) * LN_TWO) / u64_type'(LIN_DEPTH);
         t   = Q30_ONE;
         acc = Q30_ONE;
         for (int n = 1; n <= 12; n++) begin
            t   = ((t * y) >> 30) / u64_type'(n);
            acc = acc + t;
         end
         v = (acc + (64'd1 << 14)) >> 15;
         if (v > 64'd65535) v = 64'd65535;
         lin_tab[k] = v[15:0];
      end
   endfunction

   function automatic void reset_tone_model();
      tone_phase_step = 32'd0;
      tone_target     = -16'sd30720;
      tone_ramp       = 24'd4800;
      tone_phase      = 32'd0;
      tone_gain       = -2013265920;
      tone_step       = 0;
   endfunction

   // Scale a sine value by 10^(gain/20), gain in dB Q7.24; saturate the magnitude
   function automatic logic [SAMPLE_W-1:0] scale_tone(input int sine, input int gain);
      s64_type e;
      s64_type p;
      s64_type sh;
      u64_type uoff;
      u64_type frac;
      u64_type idx;
      u64_type mag;
      u64_type d;
      u64_type res;
      e    = s64_type'(gain) * DB_LOG2;
      uoff = u64_type'(e + s64_type'(64'd1 << 61));
      p    = s64_type'(uoff >> 56) - 64'sd32;
      frac = uoff & ((64'd1 << 56) - 64'd1);
      idx  = ((frac >> 20) * u64_type'(LIN_DEPTH)) >> 36;
      mag  = (sine < 0) ? u64_type'(-s64_type'(sine)) : u64_type'(sine);
      sh   = p - 64'sd15;
      if (idx >= u64_type'(LIN_DEPTH)) idx = u64_type'(LIN_DEPTH - 1);
      mag = mag * u64_type'(lin_tab[idx]);
      if (sh < 0) begin
         d = u64_type'(-sh);
         mag = (d >= 63) ? 64'd0 : ((mag + (64'd1 << (d - 1))) >> d);
      end else if (sh > 0) begin
         if (mag != 0 && sh >= 16) mag = PEAK;
         else mag = mag << sh;
      end
      if (mag > PEAK) mag = PEAK;
      res = (sine < 0) ? (64'd0 - mag) : mag;
      return res[SAMPLE_W-1:0];
   endfunction

   // Work out the sample that one request transfer yields, and advance the model
   function automatic tone_result_type predict_tone(input logic restart);
      tone_result_type res;
      s64_type tgt;
      s64_type cur;
      s64_type diff;
      s64_type q;
      s64_type mag;
      u64_type ad;
      u64_type n;
      u64_type sidx;
      int      sine;
      tgt = s64_type'(tone_target) * 64'sd65536;
      cur = s64_type'(tone_gain);
      if (restart) begin
         // rounded-up step so the ramp lands within ramp_samples; zero length acts as one
         diff = tgt - cur;
         ad   = (diff < 0) ? u64_type'(-diff) : u64_type'(diff);
         n    = (tone_ramp == 0) ? 64'd1 : u64_type'(tone_ramp);
         q    = s64_type'((ad + n - 64'd1) / n);
         if (q > STEP_LIMIT) q = STEP_LIMIT;
         tone_step = (diff < 0) ? -int'(q) : int'(q);
      end
      sidx = (u64_type'(tone_phase) * u64_type'(SINE_DEPTH)) >> 32;
      if (sidx >= u64_type'(SINE_DEPTH)) sidx = u64_type'(SINE_DEPTH - 1);
      sine       = sine_tab[sidx];
      tone_phase = tone_phase + tone_phase_step;
      // direction follows current versus target; never step past the target
      mag = (tone_step < 0) ? -s64_type'(tone_step) : s64_type'(tone_step);
      if (cur < tgt) begin
         cur = cur + mag;
         if (cur > tgt) cur = tgt;
      end else if (cur > tgt) begin
         cur = cur - mag;
         if (cur < tgt) cur = tgt;
      end
      tone_gain   = int'(cur);
      res.sample  = scale_tone(sine, tone_gain);
      res.gain_db = tone_gain[31:16];
      res.done    = (cur == tgt);
      return res;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Request side: note each transfer and predict its sample at the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) tone_expected_q.push_back(predict_tone(req_restart_ramp));
   end

   // Request driver: hold valid and payload until the transfer, then idle or load the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (tone_pending_q.size() > 0) begin
            req_valid        <= 1'b1;
            req_restart_ramp <= tone_pending_q.pop_front();
            send_gap = quiet_sender ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left     = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (quiet_receiver) begin
         rsp_ready <= 1'b1;
      end else begin
         hold_left = pick_gap();
         if (hold_left == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // Response monitor: compare each transfer with the oldest predicted sample
   always @(posedge clock) begin : rsp_monitor
      tone_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         sample_count = sample_count + 1;
         if (tone_expected_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("sample %0d: response with no request outstanding", sample_count);
         end else begin
            want = tone_expected_q.pop_front();
            if (rsp_sample_out !== want.sample || rsp_gain_now_db !== want.gain_db
                || rsp_ramp_done !== want.done) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("sample %0d: expected %0d/%0d/%0b got %0d/%0d/%0b", sample_count,
                           want.sample, want.gain_db, want.done,
                           rsp_sample_out, rsp_gain_now_db, rsp_ramp_done);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold until nothing is queued, offered or outstanding
   task automatic wait_drained();
      do @(posedge clock);
      while (tone_pending_q.size() != 0 || req_valid || tone_expected_q.size() != 0);
   endtask

   // One register write transfer; mirror it into the model once it has gone through
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_PHASE_STEP:     tone_phase_step = data;
         CSR_TARGET_GAIN_DB: tone_target     = data[15:0];
         CSR_RAMP_SAMPLES:   tone_ramp       = data[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] step_val;
      logic [15:0] tgt_val;
      logic [23:0] ramp_val;
      int          pick;
      int          count;
      build_tone_tables();
      reset_tone_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // At reset defaults: the step is zero, so a restart towards -120 dB leaves the gain put
      tone_pending_q.push_back(1'b0);
      tone_pending_q.push_back(1'b1);
      wait_drained();

      // Quarter-turn steps and the loudest target in one sample: step saturates, sample clips
      write_csr(CSR_PHASE_STEP, 32'h4000_0000);
      write_csr(CSR_TARGET_GAIN_DB, 32'h0000_7FFF);
      write_csr(CSR_RAMP_SAMPLES, 32'h0000_0001);
      tone_pending_q.push_back(1'b1);
      repeat (3) tone_pending_q.push_back(1'b0);
      wait_drained();

      // Quietest target with a zero ramp length, taken as one sample
      write_csr(CSR_TARGET_GAIN_DB, 32'hFFFF_8000);
      write_csr(CSR_RAMP_SAMPLES, 32'h0000_0000);
      tone_pending_q.push_back(1'b1);
      tone_pending_q.push_back(1'b0);
      wait_drained();

      // Largest phase step (wraps backwards) and a short ramp to 0 dB
      write_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_TARGET_GAIN_DB, 32'h0000_0000);
      write_csr(CSR_RAMP_SAMPLES, 32'h0000_0004);
      tone_pending_q.push_back(1'b1);
      repeat (4) tone_pending_q.push_back(1'b0);
      wait_drained();

      // New target without a restart: the old step size carries on towards it
      write_csr(CSR_TARGET_GAIN_DB, 32'h0000_0500);
      repeat (3) tone_pending_q.push_back(1'b0);
      wait_drained();

      // Longest ramp, junk in the unused data bits, and a write to the spare index
      write_csr(CSR_RAMP_SAMPLES, 32'h5AFF_FFFF);
      write_csr(CSR_TARGET_GAIN_DB, 32'hABCD_8000);
      write_csr(CSR_UNUSED, $urandom);
      tone_pending_q.push_back(1'b1);
      tone_pending_q.push_back(1'b0);
      wait_drained();

      // Random phases: new settings, then a run of samples mostly following one restart
      for (int ph = 0; ph < 12; ph++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) step_val = $urandom;
         else if (pick < 70) step_val = $urandom_range(0, 32'h0100_0000);
         else if (pick < 85) step_val = 32'd0;
         else step_val = 32'hFFFF_FFFF;

         pick = $urandom_range(0, 99);
         if (pick < 50) tgt_val = 16'($urandom_range(0, 12800) - 7680);
         else if (pick < 80) tgt_val = 16'($urandom);
         else if (pick < 90) tgt_val = 16'h7FFF;
         else tgt_val = 16'h8000;

         pick = $urandom_range(0, 99);
         if (pick < 70) ramp_val = 24'($urandom_range(1, 24));
         else if (pick < 80) ramp_val = 24'd0;
         else if (pick < 90) ramp_val = 24'hFF_FFFF;
         else ramp_val = 24'($urandom);

         // Mostly a full set of writes; sometimes the target alone
         if ($urandom_range(0, 99) < 80) begin
            write_csr(CSR_PHASE_STEP, step_val);
            write_csr(CSR_RAMP_SAMPLES, {8'($urandom), ramp_val});
         end
         write_csr(CSR_TARGET_GAIN_DB, {16'($urandom), tgt_val});
         if ($urandom_range(0, 99) < 15) write_csr(CSR_UNUSED, $urandom);

         quiet_sender   = ($urandom_range(0, 3) == 0);
         quiet_receiver = ($urandom_range(0, 3) == 0);
         if (ph == 3) begin
            // Receiver holds off while requests keep coming, so the block backs up
            quiet_sender  = 1'b1;
            long_hold_ask = 1'b1;
         end

         count = $urandom_range(35, 40);
         tone_pending_q.push_back($urandom_range(0, 99) < 80);
         for (int i = 1; i < count; i++) begin
            // Pause the sender halfway through one phase until every sample is back
            if (ph == 6 && i == count / 2) wait_drained();
            tone_pending_q.push_back($urandom_range(0, 99) < 8);
         end
         wait_drained();
      end

      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && tone_expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
